// ===== hdl/ira_pkg.sv =====
// ira_pkg: shared types and constants for the interval room allocator
// request and result payload structs, scan unit control struct
// no dependencies
`default_nettype none

package ira_pkg;

  localparam int TIME_BITS     = 32;
  localparam int TAG_BITS      = 16;
  localparam int ROOM_W        = 7;
  localparam int MAX_ROOMS_DEF = 64;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] depart_time;
    logic [TAG_BITS-1:0]  tag;
    logic                 new_batch;
  } req_t;

  typedef struct packed {
    logic [ROOM_W-1:0]   room;
    logic [TAG_BITS-1:0] tag_out;
    logic [ROOM_W-1:0]   rooms_in_use;
    logic                overflow;
  } res_t;

  // control of the shared compare unit
  typedef struct packed {
    logic load;    // read data valid this cycle
    logic first;   // first entry of the scan, taken unconditionally
    logic decide;  // compare request start against the kept minimum
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ira_ram.sv =====
// ira_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ira_minscan.sv =====
// ira_minscan: shared compare unit that keeps the running minimum departure
// and its room index; reused for the final reuse check against start time
// depends on ira_pkg
`default_nettype none

module ira_minscan #(
  parameter int MAX_ROOMS = 64
) (
  input  wire logic                              clk,
  input  wire ira_pkg::scan_ctl_t                ctl,
  input  wire logic [$clog2(MAX_ROOMS)-1:0]      idx,
  input  wire logic [ira_pkg::TIME_BITS-1:0]     data,
  input  wire logic [ira_pkg::TIME_BITS-1:0]     start,
  output logic      [$clog2(MAX_ROOMS)-1:0]      best_idx,
  output logic                                   le
);

  import ira_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROOMS);

  logic [TIME_BITS-1:0] best_val_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_BITS-1:0] cmp_a;

  // one comparator: data <= best while scanning, start <= best when deciding
  assign cmp_a    = ctl.decide ? start : data;
  assign le       = (cmp_a <= best_val_r);
  assign best_idx = best_idx_r;

  // ties go to the later (higher) room
  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.first || le)) begin
      best_val_r <= data;
      best_idx_r <= idx;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/interval_room_allocator.sv =====
// interval_room_allocator: greedy interval partitioning of ordered requests
// an accepted request is scanned against the departure store (scan skipped
// on a new batch or an empty block), then decided into the output register
// once that is free; a new request is taken only when the block is idle, and
// the scan reads one store entry per cycle through one read port
// reset: rst_n synchronous active low clears sequencer, room count, out valid
`default_nettype none

module interval_room_allocator #(
  parameter int MAX_ROOMS = ira_pkg::MAX_ROOMS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ira_pkg::req_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ira_pkg::res_t        out_data
);

  import ira_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROOMS);
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);
  localparam int EXT_W = (CNT_W > ROOM_W) ? CNT_W : ROOM_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(MAX_ROOMS);

  // sequencer state
  logic [1:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] open_r, open_nxt;     // rooms open in this batch
  logic [CNT_W-1:0] addr_r, addr_nxt;     // next store entry to read
  logic             pend_r, pend_nxt;     // read data arrives this cycle
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  res_t             out_data_r, out_data_nxt;

  // store and compare unit hookup
  logic                 issue;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] rd_data;
  scan_ctl_t            scan_ctl;
  logic [IDX_W-1:0]     best_idx;
  logic                 le;

  // decide step
  logic             out_free;
  logic             fire;
  logic             reuse;
  logic             room_left;
  logic [EXT_W-1:0] room_wide;
  logic [EXT_W-1:0] use_wide;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // issue one read per cycle until every open room has been read
  assign issue = (state_r == ST_SCAN) && (addr_r != open_r);

  assign scan_ctl.load   = (state_r == ST_SCAN) && pend_r;
  assign scan_ctl.first  = (pend_idx_r == '0);
  assign scan_ctl.decide = (state_r == ST_DECIDE);

  // reuse the minimum room only if it frees strictly before the start
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = (state_r == ST_DECIDE) && out_free;
  assign reuse     = (open_r != '0) && !le;
  assign room_left = (open_r != ROOM_LIMIT);

  assign wr_en   = fire && (reuse || room_left);
  assign wr_addr = reuse ? best_idx : open_r[IDX_W-1:0];

  ira_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(MAX_ROOMS)
  ) u_free_after (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(req_r.depart_time),
    .rd_en  (issue),
    .rd_addr(addr_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  ira_minscan #(
    .MAX_ROOMS(MAX_ROOMS)
  ) u_minscan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .idx     (pend_idx_r),
    .data    (rd_data),
    .start   (req_r.start_time),
    .best_idx(best_idx),
    .le      (le)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    open_nxt      = open_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    room_wide     = '0;
    use_wide      = EXT_W'(open_r);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          addr_nxt = '0;
          // new batch closes every room before this request
          if (in_data.new_batch) begin
            open_nxt  = '0;
            state_nxt = ST_DECIDE;
          end else if (open_r == '0) begin
            state_nxt = ST_DECIDE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = addr_r[IDX_W-1:0];
          addr_nxt     = addr_r + CNT_W'(1);
        end else begin
          // last read data is folded in this cycle
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (out_free) begin
          if (reuse) begin
            room_wide = EXT_W'(best_idx) + EXT_W'(1);
          end else if (room_left) begin
            open_nxt  = open_r + CNT_W'(1);
            room_wide = EXT_W'(open_r) + EXT_W'(1);
            use_wide  = EXT_W'(open_r) + EXT_W'(1);
          end
          out_data_nxt.room         = room_wide[ROOM_W-1:0];
          out_data_nxt.tag_out      = req_r.tag;
          out_data_nxt.rooms_in_use = use_wide[ROOM_W-1:0];
          out_data_nxt.overflow     = !reuse && !room_left;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_r      <= '0;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // room count never passes the store depth
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= ROOM_LIMIT)
    else $error("open room count exceeds store depth");

  // no read is in flight while the block takes a new request
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_r)
    else $error("store read pending while idle");

  // accepting a request always takes the block out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // an overflow result carries no room and leaves the count full
  a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !reuse && !room_left) |=> (out_data.room == '0 && open_r == ROOM_LIMIT))
    else $error("overflow result inconsistent");
`endif

endmodule

`default_nettype wire
